// ===== design/mmts_pkg.sv =====
package mmts_pkg;

  localparam int QUEUE_DEPTH_DEF = 8;

  localparam logic [15:0] TIMEOUT_RESET = 16'd50;
  localparam logic [2:0]  BAUD_RESET    = 3'd3;
  localparam logic [7:0]  EXC_FLAG      = 8'h80;
  localparam logic [7:0]  EXC_ADDR      = 8'd1;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_TX     = 2'd1,
    PH_AWAIT  = 2'd2,
    PH_SILENT = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    ACT_TICK  = 2'd0,
    ACT_QUEUE = 2'd1,
    ACT_BLOCK = 2'd2,
    ACT_RESET = 2'd3
  } action_t;

  typedef enum logic [3:0] {
    EV_NONE      = 4'd0,
    EV_FLUSH_TX  = 4'd1,
    EV_TO_RX     = 4'd2,
    EV_ASYNC_RPL = 4'd3,
    EV_SYNC_RPL  = 4'd4,
    EV_SYNC_TMO  = 4'd5,
    EV_SYNC_EXC  = 4'd6,
    EV_ASYNC_DRP = 4'd7,
    EV_QUEUED    = 4'd8,
    EV_Q_REFUSED = 4'd9,
    EV_BUSY      = 4'd10
  } event_t;

  typedef enum logic [1:0] {
    REG_TIMEOUT = 2'd0,
    REG_BAUD    = 2'd1
  } reg_index_t;

  // silence interval in ticks per baud selection, codes above 5 act as 5
  function automatic logic [4:0] silence_ticks(input logic [2:0] baud);
    logic [4:0] t;
    case (baud)
      3'd0:    t = 5'd16;
      3'd1:    t = 5'd8;
      3'd2:    t = 5'd4;
      default: t = 5'd2;
    endcase
    return t;
  endfunction

endpackage

// ===== design/modbus_master_transaction_sequencer.sv =====
// Master-side Modbus RTU transaction sequencer.
// Input channel (in_*): one beat is one event, either a millisecond tick, an
// async request to queue, a blocking request to start, or a reset action.
// The tick beat also carries the transmitter and receiver status (tx_empty,
// rx_count and the first three received bytes).
// Output channel (out_*): exactly one result beat per input beat, in order,
// carrying the event code, its tag, the read length, the exception value and
// the line direction and phase after the event.
// Config channel (cfg_*): index 0 writes the reply timeout, index 1 the baud
// selection; always ready, meant to be written while the block is idle.
// The result of a beat is registered and shown in the cycle after acceptance.
// Throughput: one beat per cycle; all event work is one pass of logic from the
// current state and the beat into the state and the result register, with the
// async queue head prefetched into a register by the queue memory read port.
// Stall: in_ready drops only while a result waits and out_ready is low, so a
// stalled receiver holds the result and blocks the next beat, nothing is lost.
// Reset (rst_n low, synchronous): idle phase, empty queue, no current request,
// counters cleared, timeout 50 ticks, baud selection 3. Queue entries are not
// cleared; empty head/tail pointers keep stale entries from being read.
module modbus_master_transaction_sequencer #(
  parameter int QUEUE_DEPTH = mmts_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // input events
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_action,
  input  logic [7:0]  in_request_tag,
  input  logic [8:0]  in_reply_length,
  input  logic        in_tx_empty,
  input  logic [8:0]  in_rx_count,
  input  logic [7:0]  in_rx_first,
  input  logic [7:0]  in_rx_second,
  input  logic [7:0]  in_rx_third,
  // results
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  out_event_res,
  output logic [7:0]  out_event_tag,
  output logic [8:0]  out_read_length,
  output logic [7:0]  out_exception_value,
  output logic        out_drive_enable,
  output logic [1:0]  out_phase,
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import mmts_pkg::*;

  localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  function automatic logic [QW-1:0] ring_next(input logic [QW-1:0] i);
    return (i == QW'(QUEUE_DEPTH - 1)) ? '0 : i + 1'b1;
  endfunction

  // configuration registers
  logic [15:0] timeout_cfg_r;
  logic [2:0]  baud_r;

  // sequencer state
  phase_t       phase_r, phase_nxt;
  logic [QW-1:0] head_r, head_nxt;
  logic [QW-1:0] tail_r, tail_nxt;
  logic [7:0]   cur_tag_r, cur_tag_nxt;
  logic [8:0]   cur_len_r, cur_len_nxt;
  logic         cur_sync_r, cur_sync_nxt;
  logic [15:0]  tmo_r, tmo_nxt;
  logic [4:0]   sil_r, sil_nxt;

  // queue memory, entry is {length, tag}; qrd_r holds the entry at the tail
  logic [16:0]  qmem [QUEUE_DEPTH];
  logic [16:0]  qrd_r;
  logic         q_wr;
  logic [16:0]  q_wdata;

  // result register
  logic         out_valid_r;
  logic [3:0]   ev_r;
  logic [7:0]   etag_r;
  logic [8:0]   rdlen_r;
  logic [7:0]   exc_r;
  logic         drv_r;
  phase_t       phase_out_r;

  logic [3:0]   ev_c;
  logic [7:0]   etag_c;
  logic [8:0]   rdlen_c;
  logic [7:0]   exc_c;

  logic acc;
  logic busy, q_full, q_nonempty, expired, rx_done, exc_reply, sil_zero;
  logic [15:0] tmo_dec;
  logic [4:0]  sil_dec;
  action_t act;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid_r || out_ready;
  assign acc       = in_valid && in_ready;
  assign act       = action_t'(in_action);

  // shared decode
  assign busy       = (phase_r == PH_TX) || (phase_r == PH_AWAIT);
  assign q_full     = (ring_next(head_r) == tail_r);
  assign q_nonempty = (head_r != tail_r);
  // a nonzero timeout that counts down to zero on this tick
  assign tmo_dec    = (tmo_r != 16'd0) ? tmo_r - 16'd1 : 16'd0;
  assign expired    = (tmo_r == 16'd1);
  assign rx_done    = (in_rx_count >= cur_len_r);
  assign exc_reply  = (in_rx_count >= 9'd2) && (in_rx_first == EXC_ADDR)
                      && ((in_rx_second & EXC_FLAG) != 8'd0);
  assign sil_dec    = (sil_r != 5'd0) ? sil_r - 5'd1 : 5'd0;
  assign sil_zero   = (sil_dec == 5'd0);

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    case (act)
      ACT_RESET: phase_nxt = PH_IDLE;
      ACT_BLOCK: if (phase_r == PH_IDLE) phase_nxt = PH_TX;
      ACT_QUEUE: phase_nxt = phase_r;
      ACT_TICK: begin
        case (phase_r)
          PH_IDLE:   if (q_nonempty) phase_nxt = PH_TX;
          PH_SILENT: if (sil_zero) phase_nxt = PH_IDLE;
          PH_TX:     if (in_tx_empty) phase_nxt = PH_AWAIT;
          PH_AWAIT:  if (expired || rx_done) phase_nxt = PH_SILENT;
          default:   phase_nxt = phase_r;
        endcase
      end
      default: phase_nxt = phase_r;
    endcase
  end

  // event, queue and counter updates
  always_comb begin
    ev_c         = EV_NONE;
    etag_c       = 8'd0;
    rdlen_c      = 9'd0;
    exc_c        = 8'd0;
    head_nxt     = head_r;
    tail_nxt     = tail_r;
    cur_tag_nxt  = cur_tag_r;
    cur_len_nxt  = cur_len_r;
    cur_sync_nxt = cur_sync_r;
    tmo_nxt      = tmo_r;
    sil_nxt      = sil_r;
    q_wr         = 1'b0;
    q_wdata      = {in_reply_length, in_request_tag};
    case (act)
      ACT_RESET: begin
        head_nxt     = '0;
        tail_nxt     = '0;
        cur_tag_nxt  = 8'd0;
        cur_len_nxt  = 9'd0;
        cur_sync_nxt = 1'b0;
        tmo_nxt      = 16'd0;
        sil_nxt      = 5'd0;
      end
      ACT_BLOCK: begin
        etag_c = in_request_tag;
        if (phase_r != PH_IDLE) begin
          ev_c = EV_BUSY;
        end else begin
          ev_c         = EV_FLUSH_TX;
          cur_tag_nxt  = in_request_tag;
          cur_len_nxt  = in_reply_length;
          cur_sync_nxt = 1'b1;
          tmo_nxt      = timeout_cfg_r;
        end
      end
      ACT_QUEUE: begin
        etag_c = in_request_tag;
        if ((busy && cur_sync_r) || q_full) begin
          ev_c = EV_Q_REFUSED;
        end else begin
          ev_c     = EV_QUEUED;
          q_wr     = 1'b1;
          head_nxt = ring_next(head_r);
        end
      end
      ACT_TICK: begin
        case (phase_r)
          PH_IDLE: begin
            if (q_nonempty) begin
              ev_c         = EV_FLUSH_TX;
              etag_c       = qrd_r[7:0];
              cur_tag_nxt  = qrd_r[7:0];
              cur_len_nxt  = qrd_r[16:8];
              cur_sync_nxt = 1'b0;
              tail_nxt     = ring_next(tail_r);
              tmo_nxt      = timeout_cfg_r;
            end
          end
          PH_SILENT: sil_nxt = sil_dec;
          PH_TX:     if (in_tx_empty) ev_c = EV_TO_RX;
          PH_AWAIT: begin
            tmo_nxt = tmo_dec;
            if (expired || rx_done) begin
              etag_c = cur_tag_r;
              if (expired) begin
                if (!cur_sync_r) begin
                  ev_c = EV_ASYNC_DRP;
                end else if (exc_reply) begin
                  ev_c  = EV_SYNC_EXC;
                  exc_c = (in_rx_count >= 9'd3) ? in_rx_third : 8'd0;
                end else begin
                  ev_c = EV_SYNC_TMO;
                end
              end else begin
                ev_c    = cur_sync_r ? EV_SYNC_RPL : EV_ASYNC_RPL;
                rdlen_c = cur_len_r;
              end
              // transaction done, start the silence interval
              cur_tag_nxt  = 8'd0;
              cur_len_nxt  = 9'd0;
              cur_sync_nxt = 1'b0;
              tmo_nxt      = 16'd0;
              sil_nxt      = silence_ticks(baud_r);
            end
          end
          default: ev_c = EV_NONE;
        endcase
      end
      default: ev_c = EV_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_cfg_r <= TIMEOUT_RESET;
      baud_r        <= BAUD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (reg_index_t'(cfg_index))
        REG_TIMEOUT: timeout_cfg_r <= cfg_data;
        REG_BAUD:    baud_r        <= cfg_data[2:0];
        default:     ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_IDLE;
      head_r     <= '0;
      tail_r     <= '0;
      cur_tag_r  <= 8'd0;
      cur_len_r  <= 9'd0;
      cur_sync_r <= 1'b0;
      tmo_r      <= 16'd0;
      sil_r      <= 5'd0;
    end else if (acc) begin
      phase_r    <= phase_nxt;
      head_r     <= head_nxt;
      tail_r     <= tail_nxt;
      cur_tag_r  <= cur_tag_nxt;
      cur_len_r  <= cur_len_nxt;
      cur_sync_r <= cur_sync_nxt;
      tmo_r      <= tmo_nxt;
      sil_r      <= sil_nxt;
    end
  end

  // queue memory: one write port at the head, registered read at the next tail,
  // with bypass when an entry is written into an empty queue
  always_ff @(posedge clk) begin
    if (acc && q_wr) begin
      qmem[head_r] <= q_wdata;
    end
    if (acc && q_wr && (head_r == tail_nxt)) begin
      qrd_r <= q_wdata;
    end else if (acc) begin
      qrd_r <= qmem[tail_nxt];
    end else begin
      qrd_r <= qmem[tail_r];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (acc) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      ev_r        <= ev_c;
      etag_r      <= etag_c;
      rdlen_r     <= rdlen_c;
      exc_r       <= exc_c;
      drv_r       <= (phase_nxt == PH_TX);
      phase_out_r <= phase_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_event_res       = ev_r;
  assign out_event_tag       = etag_r;
  assign out_read_length     = rdlen_r;
  assign out_exception_value = exc_r;
  assign out_drive_enable    = drv_r;
  assign out_phase           = phase_out_r;

endmodule

// ===== bench/testbench.sv =====
module testbench;
  import mmts_pkg::*;

  localparam int RING_SLOTS     = QUEUE_DEPTH_DEF;
  localparam int WATCHDOG_LIMIT = 2000;  // cycles with no beat on any channel
  localparam int LONG_HOLD      = 100;   // one long receiver hold-off
  localparam int PHASE_BEATS    = 47;    // random beats per configuration phase

  // one input beat, as queued for the driver
  typedef struct packed {
    action_t    act;
    logic [7:0] tag;
    logic [8:0] len;
    logic       txe;
    logic [8:0] rxc;
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
  } ev_item_t;

  // one result beat, as predicted
  typedef struct packed {
    event_t     ev;
    logic [7:0] tag;
    logic [8:0] rdlen;
    logic [7:0] exc;
    logic       de;
    phase_t     ph;
  } ev_result_t;

  logic        clk;
  logic        rst_n = 1'b0;

  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_action = '0;
  logic [7:0]  in_request_tag = '0;
  logic [8:0]  in_reply_length = '0;
  logic        in_tx_empty = 1'b0;
  logic [8:0]  in_rx_count = '0;
  logic [7:0]  in_rx_first = '0;
  logic [7:0]  in_rx_second = '0;
  logic [7:0]  in_rx_third = '0;

  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [3:0]  out_event_res;
  logic [7:0]  out_event_tag;
  logic [8:0]  out_read_length;
  logic [7:0]  out_exception_value;
  logic        out_drive_enable;
  logic [1:0]  out_phase;

  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  modbus_master_transaction_sequencer uut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_action           (in_action),
    .in_request_tag      (in_request_tag),
    .in_reply_length     (in_reply_length),
    .in_tx_empty         (in_tx_empty),
    .in_rx_count         (in_rx_count),
    .in_rx_first         (in_rx_first),
    .in_rx_second        (in_rx_second),
    .in_rx_third         (in_rx_third),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_event_res       (out_event_res),
    .out_event_tag       (out_event_tag),
    .out_read_length     (out_read_length),
    .out_exception_value (out_exception_value),
    .out_drive_enable    (out_drive_enable),
    .out_phase           (out_phase),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // beats waiting for the driver, results waiting for the monitor
  ev_item_t   pending_events [$];
  ev_result_t expected_events [$];
  int         fail_count = 0;

  // ---------------------------------------------------------------------------
  // sequencer prediction: own copy of phase, request ring and counters
  // ---------------------------------------------------------------------------
  phase_t      seq_phase;
  logic [16:0] seq_ring [RING_SLOTS];   // {length, tag}
  int          seq_head;
  int          seq_tail;
  logic [17:0] seq_cur;                 // {blocking, length, tag}
  logic [15:0] seq_wait_left;
  logic [4:0]  seq_quiet_left;
  logic [15:0] seq_timeout_cfg;
  logic [2:0]  seq_baud_cfg;

  function automatic int ring_next(int i);
    return (i + 1 >= RING_SLOTS) ? 0 : i + 1;
  endfunction

  function automatic void clear_sequencer();
    seq_phase      = PH_IDLE;
    seq_head       = 0;
    seq_tail       = 0;
    seq_cur        = '0;
    seq_wait_left  = '0;
    seq_quiet_left = '0;
  endfunction

  // transaction over: drop the request and hold the line quiet
  function automatic void end_transaction();
    seq_cur       = '0;
    seq_wait_left = '0;
    case (seq_baud_cfg)
      3'd0:    seq_quiet_left = 5'd16;
      3'd1:    seq_quiet_left = 5'd8;
      3'd2:    seq_quiet_left = 5'd4;
      default: seq_quiet_left = 5'd2;  // fast rates and codes above 5
    endcase
    seq_phase = PH_SILENT;
  endfunction

  function automatic ev_result_t predict_event(ev_item_t it);
    ev_result_t r;
    logic       busy;
    logic       on_sync;
    logic       expired;
    logic [7:0] cur_tag;
    logic [8:0] cur_len;
    r.ev    = EV_NONE;
    r.tag   = '0;
    r.rdlen = '0;
    r.exc   = '0;
    busy    = (seq_phase == PH_TX) || (seq_phase == PH_AWAIT);
    on_sync = seq_cur[17];
    cur_tag = seq_cur[7:0];
    cur_len = seq_cur[16:8];
    case (it.act)
      ACT_RESET: begin
        clear_sequencer();
      end
      ACT_BLOCK: begin
        r.tag = it.tag;
        if (seq_phase != PH_IDLE) begin
          r.ev = EV_BUSY;
        end else begin
          seq_cur       = {1'b1, it.len, it.tag};
          seq_wait_left = seq_timeout_cfg;
          seq_phase     = PH_TX;
          r.ev          = EV_FLUSH_TX;
        end
      end
      ACT_QUEUE: begin
        r.tag = it.tag;
        // refused while a blocking request is on the line or the ring is full
        if ((busy && on_sync) || ring_next(seq_head) == seq_tail) begin
          r.ev = EV_Q_REFUSED;
        end else begin
          seq_ring[seq_head] = {it.len, it.tag};
          seq_head           = ring_next(seq_head);
          r.ev               = EV_QUEUED;
        end
      end
      default: begin
        // millisecond tick
        case (seq_phase)
          PH_IDLE: begin
            if (seq_head != seq_tail) begin
              seq_cur       = {1'b0, seq_ring[seq_tail]};
              seq_tail      = ring_next(seq_tail);
              seq_wait_left = seq_timeout_cfg;
              seq_phase     = PH_TX;
              r.ev          = EV_FLUSH_TX;
              r.tag         = seq_cur[7:0];
            end
          end
          PH_SILENT: begin
            if (seq_quiet_left != 5'd0) seq_quiet_left = seq_quiet_left - 5'd1;
            if (seq_quiet_left == 5'd0) seq_phase = PH_IDLE;
          end
          PH_TX: begin
            if (it.txe) begin
              seq_phase = PH_AWAIT;
              r.ev      = EV_TO_RX;
            end
          end
          default: begin
            // awaiting the reply; a zero timeout never expires
            expired = 1'b0;
            if (seq_wait_left != 16'd0) begin
              seq_wait_left = seq_wait_left - 16'd1;
              expired       = (seq_wait_left == 16'd0);
            end
            if (expired) begin
              r.tag = cur_tag;
              if (!on_sync) begin
                r.ev = EV_ASYNC_DRP;
              end else if (it.rxc >= 9'd2 && it.b0 == EXC_ADDR &&
                           (it.b1 & EXC_FLAG) != 8'd0) begin
                r.ev  = EV_SYNC_EXC;
                r.exc = (it.rxc >= 9'd3) ? it.b2 : 8'd0;
              end else begin
                r.ev = EV_SYNC_TMO;
              end
              end_transaction();
            end else if (it.rxc >= cur_len) begin
              r.tag   = cur_tag;
              r.ev    = on_sync ? EV_SYNC_RPL : EV_ASYNC_RPL;
              r.rdlen = cur_len;
              end_transaction();
            end
          end
        endcase
      end
    endcase
    r.de = (seq_phase == PH_TX);
    r.ph = seq_phase;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus building
  // ---------------------------------------------------------------------------
  function automatic void queue_beat(action_t a, logic [7:0] tag, logic [8:0] len,
                                     logic txe, logic [8:0] rxc,
                                     logic [7:0] b0, logic [7:0] b1, logic [7:0] b2);
    ev_item_t it;
    it.act = a;
    it.tag = tag;
    it.len = len;
    it.txe = txe;
    it.rxc = rxc;
    it.b0  = b0;
    it.b1  = b1;
    it.b2  = b2;
    pending_events.push_back(it);
  endfunction

  // mostly short replies, some up to the full field
  function automatic logic [8:0] pick_length();
    logic [31:0] w;
    case ($urandom_range(0, 9))
      0:       w = $urandom_range(257, 511);
      1, 2:    w = $urandom_range(9, 256);
      default: w = $urandom_range(0, 8);
    endcase
    return w[8:0];
  endfunction

  // request beat with random tag and random status fields
  function automatic void queue_request(action_t a, logic [8:0] len);
    logic [31:0] r;
    logic [31:0] s;
    r = $urandom;
    s = $urandom;
    queue_beat(a, r[7:0], len, r[8], r[17:9], s[7:0], s[15:8], s[23:16]);
  endfunction

  // tick with receiver status around the expected length, often shaped
  // like an exception reply
  function automatic void queue_tick(logic [8:0] hint, logic hold_tx);
    logic [31:0] r;
    logic [31:0] s;
    logic [31:0] w;
    logic [7:0]  b0;
    logic [7:0]  b1;
    r = $urandom;
    s = $urandom;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: w = $urandom_range(0, {23'd0, hint} + 32'd1);
      6:                w = $urandom_range(0, 4);
      7:                w = $urandom;
      default:          w = {23'd0, hint};
    endcase
    if (w > 32'd511) w = 32'd511;
    b0 = r[24] ? EXC_ADDR : r[7:0];
    b1 = r[25] ? (r[15:8] | EXC_FLAG) : r[15:8];
    queue_beat(ACT_TICK, s[7:0], s[16:8], !hold_tx && (r[27:26] != 2'b00), w[8:0],
               b0, b1, r[23:16]);
  endfunction

  // ---------------------------------------------------------------------------
  // driver: bursts of beats with random gaps
  // ---------------------------------------------------------------------------
  ev_item_t on_wire;
  int       burst_left = 4;
  int       gap_left   = 0;

  always @(posedge clk) begin
    if (rst_n) begin
      // register writes only land while no beat is in flight
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_TIMEOUT) seq_timeout_cfg = cfg_data;
        else if (cfg_index == REG_BAUD) seq_baud_cfg = cfg_data[2:0];
      end
      if (in_valid && in_ready) expected_events.push_back(predict_event(on_wire));
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_events.size() > 0) begin
          on_wire = pending_events.pop_front();
          in_action       <= on_wire.act;
          in_request_tag  <= on_wire.tag;
          in_reply_length <= on_wire.len;
          in_tx_empty     <= on_wire.txe;
          in_rx_count     <= on_wire.rxc;
          in_rx_first     <= on_wire.b0;
          in_rx_second    <= on_wire.b1;
          in_rx_third     <= on_wire.b2;
          in_valid        <= 1'b1;
          if (burst_left > 1) begin
            burst_left--;
          end else if ($urandom_range(0, 3) == 0) begin
            // long back-to-back stretch
            burst_left = $urandom_range(20, 60);
            gap_left   = 0;
          end else begin
            burst_left = $urandom_range(1, 8);
            gap_left   = $urandom_range(1, 6);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: result check and receiver stall pattern
  // ---------------------------------------------------------------------------
  ev_result_t want;
  int         cyc       = 0;
  int         hold_left = 0;
  logic       hold_done = 1'b0;

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_events.size() == 0) begin
          $error("result beat with no event pending: event_res %0d tag %0d",
                 out_event_res, out_event_tag);
          fail_count++;
        end else begin
          want = expected_events.pop_front();
          if (out_event_res !== want.ev) begin
            $error("event_res: expected %0d, got %0d", want.ev, out_event_res);
            fail_count++;
          end
          if (out_event_tag !== want.tag) begin
            $error("event_tag: expected %0d, got %0d", want.tag, out_event_tag);
            fail_count++;
          end
          if (out_read_length !== want.rdlen) begin
            $error("read_length: expected %0d, got %0d", want.rdlen, out_read_length);
            fail_count++;
          end
          if (out_exception_value !== want.exc) begin
            $error("exception_value: expected %0d, got %0d", want.exc, out_exception_value);
            fail_count++;
          end
          if (out_drive_enable !== want.de) begin
            $error("drive_enable: expected %0d, got %0d", want.de, out_drive_enable);
            fail_count++;
          end
          if (out_phase !== want.ph) begin
            $error("phase: expected %0d, got %0d", want.ph, out_phase);
            fail_count++;
          end
        end
      end

      cyc++;
      // one long hold-off while the driver still has plenty to send
      if (!hold_done && pending_events.size() > 40) begin
        hold_done = 1'b1;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        case ((cyc / 64) % 4)
          0:       out_ready <= 1'b1;
          1:       out_ready <= ($urandom_range(0, 9) > 2);
          2:       out_ready <= ((cyc % 7) > 1);
          default: out_ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // watchdog: no beat on any channel for too long
  // ---------------------------------------------------------------------------
  int idle_cycles = 0;

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------
  task automatic write_reg(reg_index_t idx, logic [15:0] value);
    @(posedge clk);
    cfg_index <= idx;
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // wait until every queued beat went out and every result came back
  task automatic drain();
    @(negedge clk);
    while (pending_events.size() != 0 || in_valid || expected_events.size() != 0)
      @(negedge clk);
    repeat (3) @(posedge clk);
  endtask

  initial begin
    int          tmo_set [8];
    int          baud_set [8];
    int          start_size;
    int          n;
    logic [31:0] junk;
    logic [8:0]  len;

    tmo_set  = '{3, 1, 0, 65535, 7, 2, 20, 50};
    baud_set = '{0, 5, 1, 2, 6, 7, 4, 3};

    clear_sequencer();
    seq_timeout_cfg = TIMEOUT_RESET;
    seq_baud_cfg    = BAUD_RESET;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // directed part runs with a two-tick reply timeout, default baud
    write_reg(REG_TIMEOUT, 16'd2);
    @(negedge clk);
    queue_beat(ACT_TICK,  8'h00, 9'd0,   1'b0, 9'd0,   8'h00, 8'h00, 8'h00);  // idle, empty
    queue_beat(ACT_BLOCK, 8'hff, 9'd0,   1'b1, 9'd511, 8'hff, 8'hff, 8'hff);  // zero length
    queue_beat(ACT_BLOCK, 8'h00, 9'd511, 1'b0, 9'd0,   8'h00, 8'h00, 8'h00);  // busy
    queue_beat(ACT_QUEUE, 8'h5a, 9'd3,   1'b0, 9'd0,   8'h00, 8'h00, 8'h00);  // sync in flight
    queue_beat(ACT_TICK,  8'h00, 9'd0,   1'b0, 9'd0,   8'h00, 8'h00, 8'h00);  // still sending
    queue_beat(ACT_TICK,  8'h00, 9'd0,   1'b1, 9'd0,   8'h00, 8'h00, 8'h00);  // turn around
    queue_beat(ACT_TICK,  8'h00, 9'd0,   1'b0, 9'd0,   8'h00, 8'h00, 8'h00);  // reply at once
    queue_beat(ACT_TICK,  8'h00, 9'd0,   1'b0, 9'd0,   8'h00, 8'h00, 8'h00);  // silence
    queue_beat(ACT_TICK,  8'h00, 9'd0,   1'b0, 9'd0,   8'h00, 8'h00, 8'h00);
    queue_beat(ACT_BLOCK, 8'h81, 9'd256, 1'b0, 9'd0,   8'h00, 8'h00, 8'h00);
    queue_beat(ACT_TICK,  8'h00, 9'd0,   1'b1, 9'd0,   8'h00, 8'h00, 8'h00);
    queue_beat(ACT_TICK,  8'h00, 9'd0,   1'b0, 9'd2,   8'h01, 8'h80, 8'h00);  // not yet
    queue_beat(ACT_TICK,  8'h00, 9'd0,   1'b0, 9'd3,   8'h01, 8'hff, 8'hab);  // exception
    queue_beat(ACT_TICK,  8'h00, 9'd0,   1'b0, 9'd0,   8'h00, 8'h00, 8'h00);
    queue_beat(ACT_TICK,  8'h00, 9'd0,   1'b0, 9'd0,   8'h00, 8'h00, 8'h00);
    queue_beat(ACT_BLOCK, 8'h3c, 9'd5,   1'b0, 9'd0,   8'h00, 8'h00, 8'h00);
    queue_beat(ACT_TICK,  8'h00, 9'd0,   1'b1, 9'd0,   8'h00, 8'h00, 8'h00);
    queue_beat(ACT_TICK,  8'h00, 9'd0,   1'b0, 9'd1,   8'h01, 8'h80, 8'h00);
    queue_beat(ACT_TICK,  8'h00, 9'd0,   1'b0, 9'd2,   8'h01, 8'h80, 8'h77);  // no third byte
    queue_beat(ACT_RESET, 8'h00, 9'd0,   1'b0, 9'd0,   8'h00, 8'h00, 8'h00);  // from silence
    queue_beat(ACT_QUEUE, 8'h00, 9'd511, 1'b0, 9'd0,   8'h00, 8'h00, 8'h00);
    queue_beat(ACT_TICK,  8'h00, 9'd0,   1'b0, 9'd0,   8'h00, 8'h00, 8'h00);  // dequeue
    queue_beat(ACT_TICK,  8'h00, 9'd0,   1'b1, 9'd0,   8'h00, 8'h00, 8'h00);
    queue_beat(ACT_TICK,  8'h00, 9'd0,   1'b0, 9'd0,   8'h00, 8'h00, 8'h00);
    queue_beat(ACT_TICK,  8'h00, 9'd0,   1'b0, 9'd4,   8'h01, 8'h80, 8'h00);  // async dropped
    drain();

    // random phases, each under its own timeout and baud setting
    for (int p = 0; p < 8; p++) begin
      junk = $urandom;
      write_reg(REG_TIMEOUT, tmo_set[p][15:0]);
      write_reg(REG_BAUD, {junk[12:0], baud_set[p][2:0]});
      @(negedge clk);
      start_size = pending_events.size();
      while (pending_events.size() - start_size < PHASE_BEATS) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3: begin
            // blocking transaction: start, send, then wait for reply
            len = pick_length();
            queue_request(ACT_BLOCK, len);
            n = $urandom_range(0, 3);
            repeat (n) queue_tick(len, 1'b1);
            n = $urandom_range(4, 24);
            repeat (n) begin
              if ($urandom_range(0, 9) == 0)
                queue_request($urandom_range(0, 1) ? ACT_QUEUE : ACT_BLOCK, pick_length());
              else
                queue_tick(len, 1'b0);
            end
          end
          4, 5, 6: begin
            // async burst, sometimes past the ring capacity
            n = $urandom_range(1, RING_SLOTS + 1);
            repeat (n) queue_request(ACT_QUEUE, pick_length());
            n = $urandom_range(6, 40);
            repeat (n) queue_tick(pick_length(), 1'b0);
          end
          7, 8: begin
            // noise: any action, any field value
            n = $urandom_range(1, 6);
            repeat (n) begin
              junk = $urandom;
              case ($urandom_range(0, 19))
                0:                      queue_request(ACT_RESET, junk[8:0]);
                1, 2, 3, 4, 5, 6, 7:    queue_request(ACT_TICK, junk[8:0]);
                8, 9, 10, 11, 12, 13:   queue_request(ACT_QUEUE, junk[8:0]);
                default:                queue_request(ACT_BLOCK, junk[8:0]);
              endcase
            end
          end
          default: begin
            n = $urandom_range(3, 20);
            repeat (n) queue_tick(pick_length(), 1'b0);
          end
        endcase
      end
      drain();
    end

    repeat (5) @(posedge clk);
    if (fail_count == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

// ===== modbus_master_transaction_sequencer.f =====
design/mmts_pkg.sv
design/modbus_master_transaction_sequencer.sv
bench/testbench.sv
